// ===== rtl/core/dhsrc_pkg.sv =====
// ----------------------------------------------------------------------------
// dhsrc_pkg
// Types, codes and helpers for the canonical-key double hashing set.
// ----------------------------------------------------------------------------
package dhsrc_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STS_INSERTED  = 3'd0,
        STS_PRESENT   = 3'd1,
        STS_FOUND     = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_FULL      = 3'd4,
        STS_CLEARED   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MUL,
        ST_SUB,
        ST_FIX,
        ST_START,
        ST_PROBE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] id;
        logic        flag;
        logic [5:0]  pins;
    } slot_t;

    localparam int unsigned PROBE_W   = 12;
    localparam int unsigned PROBE_MAX = 4095;

    // largest of the word and its byte rotations
    function automatic logic [31:0] canonical(input logic [31:0] id);
        logic [31:0] r8;
        logic [31:0] r16;
        logic [31:0] r24;
        logic [31:0] best;
        r8   = {id[23:0], id[31:24]};
        r16  = {id[15:0], id[31:16]};
        r24  = {id[7:0], id[31:8]};
        best = id;
        if (r8 > best) begin
            best = r8;
        end
        if (r16 > best) begin
            best = r16;
        end
        if (r24 > best) begin
            best = r24;
        end
        return best;
    endfunction

endpackage

// ===== rtl/core/double_hash_set_rotation_canonical.sv =====
// ----------------------------------------------------------------------------
// double_hash_set_rotation_canonical
// Open-addressing hash set with double hashing over canonical 32-bit keys.
//
//   channel | direction | ports                                   | handshake
//   s_      | in        | command, key_id, key_flag, key_pins     | valid/ready
//   m_      | out       | status, canonical_id, probe_count       | valid/ready
//
// Insert and search: hashing in two passes through one shared
// reciprocal-multiply remainder unit, then slot-by-slot probes of the slot
// memory, then the result is handed over.
// Clear and reset: a sweep that zeroes the slot memory, one row per cycle;
// no item is taken meanwhile. A stalled result waits in the output register
// while the next item is already accepted.
// ----------------------------------------------------------------------------
module double_hash_set_rotation_canonical
    import dhsrc_pkg::*;
#(
    parameter int unsigned TABLE_PRIME = 4093,
    parameter int unsigned STEP_PRIME  = 4091
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [1:0]   s_command,
    input  logic [31:0]  s_key_id,
    input  logic         s_key_flag,
    input  logic [5:0]   s_key_pins,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [2:0]   m_status,
    output logic [31:0]  m_canonical_id,
    output logic [11:0]  m_probe_count
);

    localparam int unsigned AW = $clog2(TABLE_PRIME);
    localparam int unsigned BW = $clog2(STEP_PRIME);
    localparam int unsigned CW = $clog2(TABLE_PRIME + 1);
    localparam int unsigned S1 = 31 + AW;
    localparam int unsigned S2 = 31 + BW;
    localparam logic [63:0] M1_W = (64'd1 << S1) / 64'(TABLE_PRIME);
    localparam logic [63:0] M2_W = (64'd1 << S2) / 64'(STEP_PRIME);
    localparam logic [31:0] M1 = M1_W[31:0];
    localparam logic [31:0] M2 = M2_W[31:0];
    localparam logic [AW:0] P1_X = (AW + 1)'(TABLE_PRIME);
    localparam logic [BW:0] P2_X = (BW + 1)'(STEP_PRIME);
    localparam logic [AW-1:0] LAST_ROW = AW'(TABLE_PRIME - 1);
    localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_PRIME);

    slot_t slot_mem [TABLE_PRIME];

    state_t          state_reg, state_next;
    cmd_t            cmd_reg;
    logic [31:0]     canon_reg;
    logic            flag_reg;
    logic [5:0]      pins_reg;
    logic [31:0]     x_reg;
    logic            pass2_reg;
    logic            report_reg;
    logic [31:0]     q1_reg, q2_reg;
    logic [AW:0]     r1_reg;
    logic [BW:0]     r2_reg;
    logic [AW-1:0]   pos_reg, nxt_reg, step_reg, clr_reg;
    logic [CW-1:0]   cnt_reg;
    slot_t           rd_slot;
    status_t         res_status_reg;
    logic [31:0]     res_id_reg;
    logic [PROBE_W-1:0] res_probes_reg;
    logic            m_valid_reg;
    logic [2:0]      m_status_reg;
    logic [31:0]     m_id_reg;
    logic [11:0]     m_probes_reg;

    logic            accept;
    cmd_t            s_cmd;
    logic [63:0]     prod1, prod2, diff1, diff2;
    logic [AW:0]     fix1_w;
    logic [BW:0]     fix2_w;
    logic [AW-1:0]   fix1, step_mod;
    logic [BW-1:0]   fix2;
    logic [AW:0]     start_sum, probe_sum;
    logic [AW-1:0]   start_nxt, probe_nxt;
    logic            slot_empty, slot_match, probe_last, probe_end;
    logic [31:0]     cnt_wide;
    logic [PROBE_W-1:0] cnt_sat;
    logic            out_load;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    slot_t           mem_wdata;

    assign s_cmd  = cmd_t'(s_command);
    assign accept = s_valid && s_ready;

    // shared remainder unit
    assign prod1 = 64'(x_reg) * 64'(M1);
    assign prod2 = 64'(canon_reg) * 64'(M2);
    assign diff1 = 64'(x_reg) - 64'(q1_reg) * 64'(TABLE_PRIME);
    assign diff2 = 64'(canon_reg) - 64'(q2_reg) * 64'(STEP_PRIME);
    assign fix1_w = (r1_reg >= P1_X) ? (r1_reg - P1_X) : r1_reg;
    assign fix2_w = (r2_reg >= P2_X) ? (r2_reg - P2_X) : r2_reg;
    assign fix1   = fix1_w[AW-1:0];
    assign fix2   = fix2_w[BW-1:0];
    assign step_mod = fix1;

    // next probe position
    assign start_sum = {1'b0, pos_reg} + {1'b0, step_reg};
    assign start_nxt = (start_sum >= P1_X) ? AW'(start_sum - P1_X) : start_sum[AW-1:0];
    assign probe_sum = {1'b0, nxt_reg} + {1'b0, step_reg};
    assign probe_nxt = (probe_sum >= P1_X) ? AW'(probe_sum - P1_X) : probe_sum[AW-1:0];

    assign slot_empty = (rd_slot.id == 32'd0);
    assign slot_match = (rd_slot.id == canon_reg) && (rd_slot.flag == flag_reg);
    assign probe_last = (cnt_reg == CNT_LAST);
    assign probe_end  = slot_empty || slot_match || probe_last;

    assign cnt_wide = 32'(cnt_reg);
    assign cnt_sat  = (cnt_wide > 32'(PROBE_MAX)) ? PROBE_W'(PROBE_MAX)
                                                  : cnt_wide[PROBE_W-1:0];

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_cmd == CMD_CLEAR) begin
                        state_next = ST_CLEAR;
                    end else if (s_cmd != CMD_NONE) begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_CLEAR: begin
                if (clr_reg == LAST_ROW) begin
                    state_next = report_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_MUL:   state_next = ST_SUB;
            ST_SUB:   state_next = ST_FIX;
            ST_FIX:   state_next = pass2_reg ? ST_START : ST_MUL;
            ST_START: state_next = ST_PROBE;
            ST_PROBE: begin
                if (probe_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = clr_reg;
        mem_wdata = '0;
        mem_raddr = pos_reg;
        unique case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_CLEAR: mem_we  = 1'b1;
            ST_PROBE: begin
                mem_raddr = nxt_reg;
                if (slot_empty && cmd_reg == CMD_INSERT) begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_reg;
                    mem_wdata = '{id: canon_reg, flag: flag_reg, pins: pins_reg};
                end
            end
            default: ;
        endcase
    end

    // slot memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rd_slot <= slot_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            report_reg  <= 1'b0;
            pass2_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= (clr_reg == LAST_ROW) ? '0 : clr_reg + 1'b1;
            end
            if (accept) begin
                report_reg <= 1'b1;
                pass2_reg  <= 1'b0;
            end else if (state_reg == ST_FIX) begin
                pass2_reg <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= s_cmd;
            canon_reg <= canonical(s_key_id);
            x_reg     <= canonical(s_key_id);
            flag_reg  <= s_key_flag;
            pins_reg  <= s_key_pins;
        end
        if (state_reg == ST_MUL) begin
            q1_reg <= 32'(prod1 >> S1);
            q2_reg <= 32'(prod2 >> S2);
        end
        if (state_reg == ST_SUB) begin
            r1_reg <= diff1[AW:0];
            r2_reg <= diff2[BW:0];
        end
        if (state_reg == ST_FIX) begin
            if (pass2_reg) begin
                step_reg <= step_mod;
            end else begin
                pos_reg <= fix1;
                x_reg   <= 32'(fix2) + 32'd1;
            end
        end
        if (state_reg == ST_START) begin
            nxt_reg <= start_nxt;
            cnt_reg <= CW'(1);
        end
        if (state_reg == ST_PROBE) begin
            if (probe_end) begin
                res_id_reg     <= canon_reg;
                res_probes_reg <= cnt_sat;
                if (slot_empty) begin
                    res_status_reg <= (cmd_reg == CMD_INSERT) ? STS_INSERTED : STS_NOT_FOUND;
                end else if (slot_match) begin
                    res_status_reg <= (cmd_reg == CMD_INSERT) ? STS_PRESENT : STS_FOUND;
                end else begin
                    res_status_reg <= (cmd_reg == CMD_INSERT) ? STS_FULL : STS_NOT_FOUND;
                end
            end else begin
                pos_reg <= nxt_reg;
                nxt_reg <= probe_nxt;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        if (state_reg == ST_CLEAR) begin
            res_status_reg <= STS_CLEARED;
            res_id_reg     <= '0;
            res_probes_reg <= '0;
        end
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_id_reg     <= res_id_reg;
            m_probes_reg <= res_probes_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_canonical_id = m_id_reg;
    assign m_probe_count  = m_probes_reg;

    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_CLEAR)
                || (state_reg == ST_PROBE && cmd_reg == CMD_INSERT))
        else $error("slot write outside clear sweep or insert");

    a_write_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && state_reg == ST_PROBE) |-> (rd_slot.id == 32'd0))
        else $error("insert overwrites an occupied slot");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE) |-> (32'(pos_reg) < TABLE_PRIME)
                                  && (32'(nxt_reg) < TABLE_PRIME))
        else $error("probe position out of table");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE) |-> (cnt_wide >= 32'd1) && (cnt_wide <= TABLE_PRIME))
        else $error("probe count out of range");

    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result appeared without a finished item");

endmodule
